### rtl/core/bcd_pkg.sv
`default_nettype none

package bcd_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned ACT_W      = 3;

  localparam int unsigned IN_FIELDS_W  = ACT_W + DATA_WIDTH;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 3 + 2 * DATA_WIDTH;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEEK       = 3'd4;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    data_t data;
  } wr_req_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

endpackage

`default_nettype wire

### rtl/core/bounded_circular_deque_unit.sv
`default_nettype none

// Double-ended queue held in a 64-entry ring store with a head pointer and
// an entry count. Front and rear values are kept in registers; the store is
// read only when a pop exposes a new front or rear entry.
// Input channel s_*: one action per transfer (push front/back, pop
// front/back, peek). Output channel m_*: one result per action with the
// accept flag, front and rear values and the empty and full flags after the
// action. Config channel cfg_*: capacity, always ready; the user must see that it is
// written only when idle, the block does not enforce this. The result is valid in
// the cycle after the input transfer, or after the S_FETCH state for a pop
// that leaves one or more entries (the synchronous store read). Items are
// processed one at a time: s_tready returns only once the result is taken.
// While a result waits for m_tready it holds and s_tready stays low.
// Reset empties the deque, clears the head pointer and sets capacity to 64;
// the store itself is not cleared and needs no clearing pass.

module bounded_circular_deque_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // action [2:0], push_value [18:3], zero [23:19]
  input  wire  [bcd_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // accepted [0], front_value [16:1], rear_value [32:17], is_empty [33],
  // is_full [34], zero [39:35]
  output logic [bcd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [bcd_pkg::CNT_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_SEND  = 3'b100
  } state_t;

  state_t                  state, state_next;
  bcd_pkg::addr_t          head, head_next;
  bcd_pkg::cnt_t           count, count_next;
  bcd_pkg::cnt_t           cap;
  bcd_pkg::data_t          front, front_next;
  bcd_pkg::data_t          rear, rear_next;
  logic                    acc, acc_next;
  logic                    fetch_front, fetch_front_next;
  bcd_pkg::wr_req_t        wr_req;
  bcd_pkg::rd_req_t        rd_req;
  bcd_pkg::data_t          rd_data;

  logic [bcd_pkg::ACT_W-1:0] action;
  bcd_pkg::data_t          push_value;
  bcd_pkg::cnt_t           cap_eff;
  logic                    in_xfer;
  logic                    room;
  logic                    filled;

  assign action     = s_tdata[bcd_pkg::ACT_W-1:0];
  assign push_value = s_tdata[bcd_pkg::ACT_W +: bcd_pkg::DATA_WIDTH];
  assign cap_eff    = (cap > bcd_pkg::DEPTH_CNT) ? bcd_pkg::DEPTH_CNT : cap;
  assign in_xfer    = s_tvalid && s_tready;
  assign room       = count < cap_eff;
  assign filled     = count != '0;

  assign s_tready  = state == S_IDLE;
  assign m_tvalid  = state == S_SEND;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    front_next       = front;
    rear_next        = rear;
    acc_next         = acc;
    fetch_front_next = fetch_front;
    wr_req           = '{en: 1'b0, addr: head, data: push_value};
    rd_req           = '{en: 1'b0, addr: head};
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          acc_next = 1'b0;
          case (action)
            bcd_pkg::ACT_PUSH_FRONT: begin
              if (room) begin
                acc_next    = 1'b1;
                head_next   = head - 1'b1;
                count_next  = count + 1'b1;
                wr_req.en   = 1'b1;
                wr_req.addr = head - 1'b1;
                front_next  = push_value;
                if (!filled) begin
                  rear_next = push_value;
                end
              end
            end
            bcd_pkg::ACT_PUSH_BACK: begin
              if (room) begin
                acc_next    = 1'b1;
                count_next  = count + 1'b1;
                wr_req.en   = 1'b1;
                wr_req.addr = head + count[bcd_pkg::ADDR_W-1:0];
                rear_next   = push_value;
                if (!filled) begin
                  front_next = push_value;
                end
              end
            end
            bcd_pkg::ACT_POP_FRONT: begin
              if (filled) begin
                acc_next         = 1'b1;
                head_next        = head + 1'b1;
                count_next       = count - 1'b1;
                rd_req.en        = count > bcd_pkg::cnt_t'(1);
                rd_req.addr      = head + 1'b1;
                fetch_front_next = 1'b1;
              end
            end
            bcd_pkg::ACT_POP_BACK: begin
              if (filled) begin
                acc_next         = 1'b1;
                count_next       = count - 1'b1;
                rd_req.en        = count > bcd_pkg::cnt_t'(1);
                rd_req.addr      = head + count[bcd_pkg::ADDR_W-1:0] - 2'd2;
                fetch_front_next = 1'b0;
              end
            end
            bcd_pkg::ACT_PEEK: begin
              acc_next = 1'b1;
            end
            default: begin
              acc_next = 1'b0;
            end
          endcase
          state_next = rd_req.en ? S_FETCH : S_SEND;
        end
      end
      S_FETCH: begin
        if (fetch_front) begin
          front_next = rd_data;
        end else begin
          rear_next = rd_data;
        end
        state_next = S_SEND;
      end
      S_SEND: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      cap   <= bcd_pkg::DEPTH_CNT;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    front       <= front_next;
    rear        <= rear_next;
    acc         <= acc_next;
    fetch_front <= fetch_front_next;
  end

  bcd_store u_store (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  always_comb begin
    m_tdata      = '0;
    m_tdata[0]   = acc;
    m_tdata[1 +: bcd_pkg::DATA_WIDTH] = filled ? front : '0;
    m_tdata[1 + bcd_pkg::DATA_WIDTH +: bcd_pkg::DATA_WIDTH] = filled ? rear : '0;
    m_tdata[1 + 2 * bcd_pkg::DATA_WIDTH] = !filled;
    m_tdata[2 + 2 * bcd_pkg::DATA_WIDTH] = count >= cap_eff;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bcd_pkg::DEPTH_CNT)
    else $error("entry count beyond store depth");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && room && (action == bcd_pkg::ACT_PUSH_FRONT ||
     action == bcd_pkg::ACT_PUSH_BACK)) |=> (count == $past(count) + 1'b1) && acc)
    else $error("accepted push did not advance count");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !filled && (action == bcd_pkg::ACT_POP_FRONT ||
     action == bcd_pkg::ACT_POP_BACK)) |=> (count == '0) && !acc && m_tvalid)
    else $error("pop on empty deque not refused");

endmodule

`default_nettype wire

### rtl/core/bcd_store.sv
`default_nettype none

module bcd_store (
  input  wire                     clk,
  input  wire bcd_pkg::wr_req_t   wr_req,
  input  wire bcd_pkg::rd_req_t   rd_req,
  output bcd_pkg::data_t          rd_data
);

  bcd_pkg::data_t mem [bcd_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data <= mem[rd_req.addr];
    end
  end

endmodule

`default_nettype wire
